[src/rrbm_pkg.sv]
// types and constants shared by the rom/ram bank mapper
package rrbm_pkg;

    localparam int ROM_OFFSET_W = 14;
    localparam int RAM_OFFSET_W = 13;
    localparam int ROM_ADDR_W   = 21;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    typedef logic [2:0] outcome_t;
    typedef logic [1:0] fault_t;

    localparam outcome_t OUTCOME_REG_SET     = 3'd0;
    localparam outcome_t OUTCOME_ROM_READ    = 3'd1;
    localparam outcome_t OUTCOME_RAM_READ    = 3'd2;
    localparam outcome_t OUTCOME_RAM_WRITTEN = 3'd3;
    localparam outcome_t OUTCOME_RAM_IGNORED = 3'd4;

    localparam fault_t FAULT_NONE     = 2'd0;
    localparam fault_t FAULT_BANK     = 2'd1;
    localparam fault_t FAULT_UNMAPPED = 2'd2;

    localparam logic ACTION_READ  = 1'b0;
    localparam logic ACTION_WRITE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANK_COUNT = 2'd1;

    localparam logic [1:0] REG_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROM_BANK   = 2'd1;
    localparam logic [1:0] REG_UPPER_BANK = 2'd2;
    localparam logic [1:0] REG_MODE       = 2'd3;

    localparam logic [2:0] REGION_RAM = 3'b101;

    localparam logic [7:0] ROM_BANK_COUNT_RESET = 8'd2;
    localparam logic [2:0] RAM_BANK_COUNT_RESET = 3'd0;

endpackage

[src/rom_ram_bank_mapper_top.sv]
// rom/ram bank mapper: bus access decode, mapper registers and external ram store
//
// usage: one bus request (action, bus_address, write_data) enters on in_valid
// and is taken at a clock edge where in_stall is low. each request gives one
// result (outcome, rom_address, data_out, fault) on out_valid, held until an
// edge where out_stall is low. the request is captured in an input register,
// decoded, and the result registered together with the external ram read.
// one request is taken every cycle while the output drains.
// a mapper register write takes effect for the very next request.
// configuration (rom_bank_count index 0, ram_bank_count index 1) is written on
// cfg_valid; cfg_ready is always high.
// reset: the mapper registers clear and the external ram is swept to zero, one
// byte per cycle, over all RAM_BANKS_MAX * 8192 bytes (32768 at the default);
// in_stall stays high for that sweep.
// when the receiver stalls, the result holds, one more request waits in the
// input register and in_stall then rises.
module rom_ram_bank_mapper_top #(
    parameter int RAM_BANKS_MAX = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [15:0]                          bus_address,
    input  logic [7:0]                           write_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rrbm_pkg::outcome_t                   outcome,
    output logic [rrbm_pkg::ROM_ADDR_W-1:0]      rom_address,
    output logic [7:0]                           data_out,
    output rrbm_pkg::fault_t                     fault,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rrbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rrbm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rrbm_pkg::*;

    localparam int RAM_DEPTH = RAM_BANKS_MAX * (1 << RAM_OFFSET_W);
    localparam int IDX_W     = $clog2(RAM_DEPTH);

    logic [7:0] rom_bank_count_reg;
    logic [2:0] ram_bank_count_reg;

    logic [3:0] ram_enable_nibble_reg;
    logic [4:0] low_rom_bank_reg;
    logic [1:0] upper_bank_reg;
    logic       banking_mode_reg;

    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic        s1_valid_reg;
    logic        s1_action_reg;
    logic [15:0] s1_addr_reg;
    logic [7:0]  s1_data_reg;

    logic                  out_valid_reg;
    outcome_t              outcome_reg;
    logic [ROM_ADDR_W-1:0] rom_address_reg;
    logic [7:0]            data_reg;
    logic                  data_from_ram_reg;
    fault_t                fault_reg;
    logic [7:0]            ram_rd_reg;

    logic [7:0] ram [RAM_DEPTH];

    logic                  adv;
    logic                  is_write;
    logic                  reg_write;
    logic [4:0]            low_eff;
    logic [6:0]            rom_bank_sel;
    logic [1:0]            ram_bank_sel;
    logic                  ram_bad;
    logic [IDX_W-1:0]      ram_idx;
    logic                  item_ram_we;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_wa;
    logic [7:0]            ram_wd;
    outcome_t              outcome_next;
    logic [ROM_ADDR_W-1:0] rom_address_next;
    logic [7:0]            data_next;
    logic                  data_from_ram_next;
    fault_t                fault_next;

    assign cfg_ready = 1'b1;
    assign adv       = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = clr_active_reg || (s1_valid_reg && !adv);
    assign is_write  = (s1_action_reg == ACTION_WRITE);
    assign reg_write = adv && is_write && !s1_addr_reg[15];

    assign low_eff      = (low_rom_bank_reg == 5'd0) ? 5'd1 : low_rom_bank_reg;
    assign rom_bank_sel = {(banking_mode_reg ? 2'b00 : upper_bank_reg), low_eff};
    assign ram_bank_sel = banking_mode_reg ? upper_bank_reg : 2'b00;
    assign ram_bad      = ({1'b0, ram_bank_sel} >= ram_bank_count_reg)
                       || (32'(ram_bank_sel) >= 32'(RAM_BANKS_MAX));
    assign ram_idx      = IDX_W'({ram_bank_sel, s1_addr_reg[RAM_OFFSET_W-1:0]});

    always_comb
    begin
        outcome_next       = OUTCOME_RAM_READ;
        rom_address_next   = '0;
        data_next          = 8'd0;
        data_from_ram_next = 1'b0;
        fault_next         = FAULT_NONE;
        item_ram_we        = 1'b0;
        if (!s1_addr_reg[15])
        begin
            if (is_write)
            begin
                outcome_next = OUTCOME_REG_SET;
                data_next    = s1_data_reg;
            end
            else if (!s1_addr_reg[14])
            begin
                outcome_next     = OUTCOME_ROM_READ;
                rom_address_next = ROM_ADDR_W'(s1_addr_reg);
                fault_next       = (rom_bank_count_reg == 8'd0) ? FAULT_BANK : FAULT_NONE;
            end
            else
            begin
                outcome_next     = OUTCOME_ROM_READ;
                rom_address_next = {rom_bank_sel, s1_addr_reg[ROM_OFFSET_W-1:0]};
                fault_next       = ({1'b0, rom_bank_sel} >= rom_bank_count_reg)
                                 ? FAULT_BANK : FAULT_NONE;
            end
        end
        else if (s1_addr_reg[15:13] == REGION_RAM)
        begin
            if (is_write)
            begin
                data_next = s1_data_reg;
                if (ram_enable_nibble_reg == 4'd0)
                begin
                    outcome_next = OUTCOME_RAM_IGNORED;
                end
                else if (ram_bad)
                begin
                    outcome_next = OUTCOME_RAM_IGNORED;
                    fault_next   = FAULT_BANK;
                end
                else
                begin
                    outcome_next = OUTCOME_RAM_WRITTEN;
                    item_ram_we  = 1'b1;
                end
            end
            else if (ram_bad)
            begin
                fault_next = FAULT_BANK;
            end
            else
            begin
                data_from_ram_next = 1'b1;
            end
        end
        else
        begin
            fault_next = FAULT_UNMAPPED;
            if (is_write)
            begin
                outcome_next = OUTCOME_RAM_IGNORED;
                data_next    = s1_data_reg;
            end
        end
    end

    assign ram_we = clr_active_reg || (adv && item_ram_we);
    assign ram_wa = clr_active_reg ? clr_idx_reg : ram_idx;
    assign ram_wd = clr_active_reg ? 8'd0 : s1_data_reg;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram[ram_wa] <= ram_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ram_rd_reg <= ram[ram_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_count_reg <= ROM_BANK_COUNT_RESET;
            ram_bank_count_reg <= RAM_BANK_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ROM_BANK_COUNT)
            begin
                rom_bank_count_reg <= cfg_data;
            end
            else if (cfg_index == CFG_RAM_BANK_COUNT)
            begin
                ram_bank_count_reg <= cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_enable_nibble_reg <= 4'd0;
            low_rom_bank_reg      <= 5'd0;
            upper_bank_reg        <= 2'd0;
            banking_mode_reg      <= 1'b0;
        end
        else if (reg_write)
        begin
            unique case (s1_addr_reg[14:13])
                REG_RAM_ENABLE: ram_enable_nibble_reg <= s1_data_reg[3:0];
                REG_ROM_BANK:   low_rom_bank_reg <= (s1_data_reg[4:0] == 5'd0)
                                                  ? 5'd1 : s1_data_reg[4:0];
                REG_UPPER_BANK: upper_bank_reg <= s1_data_reg[1:0];
                REG_MODE:       banking_mode_reg <= s1_data_reg[0];
                default:        banking_mode_reg <= s1_data_reg[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == IDX_W'(RAM_DEPTH - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_action_reg <= action;
            s1_addr_reg   <= bus_address;
            s1_data_reg   <= write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            outcome_reg       <= outcome_next;
            rom_address_reg   <= rom_address_next;
            data_reg          <= data_next;
            data_from_ram_reg <= data_from_ram_next;
            fault_reg         <= fault_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign rom_address = rom_address_reg;
    assign data_out    = data_from_ram_reg ? ram_rd_reg : data_reg;
    assign fault       = fault_reg;

    // item store never collides with the reset sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg && !(adv && item_ram_we))
        else $error("ram write from a request during reset sweep");

    // a waiting request is not lost
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("waiting request dropped");

    // unmapped addresses only yield ram read or ignored outcomes
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fault_reg == FAULT_UNMAPPED)
            |-> (outcome_reg == OUTCOME_RAM_READ || outcome_reg == OUTCOME_RAM_IGNORED))
        else $error("unmapped fault with wrong outcome");

    // rom address only carried on rom reads
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && outcome_reg != OUTCOME_ROM_READ) |-> rom_address_reg == '0)
        else $error("rom address on a non rom result");

endmodule
